FILE: rtl/core/msac_pkg.sv
// Shared types, constants and weight tables of the sensor anomaly classifier.
`default_nettype none
package msac_pkg;

	// Converter and input scaling
	localparam int ADC_BITS = 10;
	localparam int ADC_FS = (1 << ADC_BITS) - 1;
	localparam int ADC_HALF = ADC_FS / 2;
	localparam int X_W = 17;
	localparam int SCALE_N_W = ADC_BITS + 17;
	localparam int SCALE_K = SCALE_N_W + ADC_BITS;
	localparam longint unsigned SCALE_M = ((64'd1 << SCALE_K) + ADC_FS - 1) / ADC_FS;
	localparam int SCALE_M_W = $clog2(SCALE_M + 1);
	localparam int SCALE_P_W = SCALE_N_W + SCALE_M_W;

	// Network shape and fixed point formats
	localparam int MAX_UNITS = 16;
	localparam int MSAC_HIDDEN_UNITS = 4;
	localparam int NUM_CLASSES = 3;
	localparam int WT_W = 16;
	localparam int FRAC_SHIFT = 12;
	localparam int ROUND_HALF = 2048;
	localparam int ACC1_W = 32;
	localparam int H_W = 18;
	localparam int PROD2_W = WT_W + H_W;
	localparam int ACC2_W = PROD2_W + 4;
	localparam int Z_W = 22;
	localparam int T_W = Z_W + 1;

	// Exponent
	localparam int LOG2E_Q16 = 94548;
	localparam int U_MUL_W = T_W + 17;
	localparam int U_W = U_MUL_W - 16;
	localparam int N_W = U_W - 16;
	localparam int E_W = 17;
	localparam int EXP_CUTOFF = 17;
	localparam int CORR_W = 29;

	// Normalization divide
	localparam int PROB_W = 16;
	localparam int SUM_W = 18;
	localparam int DIV_D_W = E_W + 17;
	localparam int Q_W = 17;
	localparam int R_W = SUM_W;
	localparam int DIV_STEPS = Q_W;

	// Queues
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// Configuration registers
	localparam int THR_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_DANGER_THR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WARNING_THR = 1'd1;
	localparam logic [THR_W-1:0] DANGER_THR_RESET = 16'd39322;
	localparam logic [THR_W-1:0] WARNING_THR_RESET = 16'd32768;

	typedef enum logic [1:0] {
		CLASS_NORMAL = 2'd0,
		CLASS_WARNING = 2'd1,
		CLASS_DANGER = 2'd2
	} class_t;

	typedef struct packed {
		logic [ADC_BITS-1:0] temp_raw;
		logic [ADC_BITS-1:0] gas_raw;
	} in_item_t;

	typedef struct packed {
		logic [PROB_W-1:0] prob_normal;
		logic [PROB_W-1:0] prob_warning;
		logic [PROB_W-1:0] prob_danger;
		logic [1:0] class_code;
		logic led_on;
	} out_item_t;

	typedef struct packed {
		logic [NUM_CLASSES-1:0][E_W-1:0] e;
	} exp_item_t;

	typedef struct packed {
		logic [THR_W-1:0] danger;
		logic [THR_W-1:0] warning;
	} thr_cfg_t;

	function automatic logic signed [WT_W-1:0] l1_w(input int unit, input int col);
		logic signed [WT_W-1:0] w;
		case (unit)
			0: w = (col == 0) ? 16'sd4915 : -16'sd2048;
			1: w = (col == 0) ? -16'sd3277 : 16'sd5734;
			2: w = (col == 0) ? 16'sd2458 : 16'sd3686;
			3: w = (col == 0) ? -16'sd4506 : -16'sd2867;
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic signed [WT_W-1:0] l1_b(input int unit);
		logic signed [WT_W-1:0] b;
		case (unit)
			0: b = 16'sd410;
			1: b = 16'sd819;
			2: b = -16'sd410;
			3: b = 16'sd1229;
			default: b = '0;
		endcase
		return b;
	endfunction

	function automatic logic signed [WT_W-1:0] l2_w(input int cls, input int unit);
		logic signed [WT_W-1:0] w;
		case (cls * MAX_UNITS + unit)
			0: w = 16'sd3686;
			1: w = -16'sd4915;
			2: w = 16'sd1638;
			3: w = 16'sd2458;
			16: w = -16'sd2048;
			17: w = 16'sd3277;
			18: w = -16'sd1229;
			19: w = 16'sd4506;
			32: w = -16'sd3277;
			33: w = 16'sd2048;
			34: w = 16'sd3686;
			35: w = -16'sd1638;
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic signed [WT_W-1:0] l2_b(input int cls);
		logic signed [WT_W-1:0] b;
		case (cls)
			1: b = 16'sd410;
			2: b = -16'sd819;
			default: b = '0;
		endcase
		return b;
	endfunction

	// 2^(-j/16) in Q1.16 for j = 0..16.
	function automatic logic [E_W-1:0] pow2_tab(input logic [4:0] j);
		logic [E_W-1:0] v;
		case (j)
			5'd0: v = 17'd65536;
			5'd1: v = 17'd62757;
			5'd2: v = 17'd60097;
			5'd3: v = 17'd57549;
			5'd4: v = 17'd55109;
			5'd5: v = 17'd52773;
			5'd6: v = 17'd50535;
			5'd7: v = 17'd48393;
			5'd8: v = 17'd46341;
			5'd9: v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			5'd16: v = 17'd32768;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/msac_fifo.sv
// Small register queue with full and empty flags.
`default_nettype none
module msac_fifo #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [DATA_W-1:0] wdata,
	output logic full,
	input wire logic pop,
	output logic [DATA_W-1:0] rdata,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/msac_front.sv
// Front pipeline: input scaling, both perceptron layers and the softmax exponents.
`default_nettype none
module msac_front import msac_pkg::*; #(
	parameter int HIDDEN_UNITS = MSAC_HIDDEN_UNITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire in_item_t sample,
	output logic full,
	output logic q_push,
	output exp_item_t q_data,
	input wire logic q_full
);

	localparam logic signed [ACC1_W-1:0] RND1 = ACC1_W'(ROUND_HALF);
	localparam logic signed [ACC2_W-1:0] RND2 = ACC2_W'(ROUND_HALF);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [X_W-1:0] xt_s1, xg_s1;
	logic [H_W-1:0] h_s2 [HIDDEN_UNITS];
	logic signed [PROD2_W-1:0] prod_s3 [NUM_CLASSES][HIDDEN_UNITS];
	logic signed [Z_W-1:0] z_s4 [NUM_CLASSES];
	logic [T_W-1:0] t_s5 [NUM_CLASSES];
	logic [U_W-1:0] u_s6 [NUM_CLASSES];
	exp_item_t e_s7;

	// The whole pipeline moves together; it stops only when a finished item
	// cannot enter the queue.
	assign en = !v_s7 || !q_full;
	assign full = !en;
	assign q_push = v_s7 && !q_full;
	assign q_data = e_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: x = round(raw * 65536 / FS) through an exact reciprocal multiply.
	logic [SCALE_N_W-1:0] nt, ng;
	logic [SCALE_P_W-1:0] pt, pg;

	assign nt = SCALE_N_W'({sample.temp_raw, 16'd0}) + SCALE_N_W'(ADC_HALF);
	assign ng = SCALE_N_W'({sample.gas_raw, 16'd0}) + SCALE_N_W'(ADC_HALF);
	assign pt = SCALE_P_W'(nt) * SCALE_P_W'(SCALE_M);
	assign pg = SCALE_P_W'(ng) * SCALE_P_W'(SCALE_M);

	always_ff @(posedge clk) begin
		if (en) begin
			xt_s1 <= pt[SCALE_K +: X_W];
			xg_s1 <= pg[SCALE_K +: X_W];
		end
	end

	// Stage 2: hidden units with ReLU.
	logic signed [ACC1_W-1:0] xt_w, xg_w;
	assign xt_w = $signed(ACC1_W'(xt_s1));
	assign xg_w = $signed(ACC1_W'(xg_s1));

	for (genvar u = 0; u < HIDDEN_UNITS; u++) begin : g_hidden
		localparam logic signed [WT_W-1:0] WA = l1_w(u, 0);
		localparam logic signed [WT_W-1:0] WB = l1_w(u, 1);
		localparam logic signed [WT_W-1:0] B = l1_b(u);
		logic signed [ACC1_W-1:0] acc;
		logic signed [ACC1_W-1:0] rnd;

		assign acc = (ACC1_W'(B) <<< 16) + ACC1_W'(WA) * xt_w + ACC1_W'(WB) * xg_w;
		assign rnd = (acc + RND1) >>> FRAC_SHIFT;

		always_ff @(posedge clk) begin
			if (en) begin
				h_s2[u] <= rnd[ACC1_W-1] ? '0 : rnd[H_W-1:0];
			end
		end
	end

	// Stages 3 and 4: output layer products, then their sum and rounding.
	for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_logit
		localparam logic signed [WT_W-1:0] B2 = l2_b(k);
		logic signed [ACC2_W-1:0] acc;
		logic signed [ACC2_W-1:0] rnd;

		for (genvar u = 0; u < HIDDEN_UNITS; u++) begin : g_prod
			localparam logic signed [WT_W-1:0] W2 = l2_w(k, u);
			always_ff @(posedge clk) begin
				if (en) begin
					prod_s3[k][u] <= PROD2_W'(W2) * $signed(PROD2_W'(h_s2[u]));
				end
			end
		end

		always_comb begin
			acc = ACC2_W'(B2) <<< 16;
			for (int u = 0; u < HIDDEN_UNITS; u++) begin
				acc = acc + ACC2_W'(prod_s3[k][u]);
			end
		end

		assign rnd = (acc + RND2) >>> FRAC_SHIFT;

		always_ff @(posedge clk) begin
			if (en) begin
				z_s4[k] <= rnd[Z_W-1:0];
			end
		end
	end

	// Stage 5: distance of each logit below the largest one.
	logic signed [Z_W-1:0] zmax;
	always_comb begin
		zmax = z_s4[0];
		for (int k = 1; k < NUM_CLASSES; k++) begin
			if (z_s4[k] > zmax) begin
				zmax = z_s4[k];
			end
		end
	end

	for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_exp
		logic signed [T_W-1:0] diff;
		logic [U_MUL_W-1:0] umul;
		logic [N_W-1:0] n;
		logic [3:0] j;
		logic [11:0] r;
		logic [E_W-1:0] ta, tb, tdif, g;
		logic [CORR_W-1:0] corr;

		assign diff = T_W'(zmax) - T_W'(z_s4[k]);

		always_ff @(posedge clk) begin
			if (en) begin
				t_s5[k] <= diff;
			end
		end

		// Stage 6: convert to a power of two, u = t * log2(e).
		assign umul = U_MUL_W'(t_s5[k]) * U_MUL_W'(LOG2E_Q16) + U_MUL_W'(32768);

		always_ff @(posedge clk) begin
			if (en) begin
				u_s6[k] <= umul[16 +: U_W];
			end
		end

		// Stage 7: table lookup with linear interpolation, then the integer shift.
		assign n = u_s6[k][U_W-1:16];
		assign j = u_s6[k][15:12];
		assign r = u_s6[k][11:0];
		assign ta = pow2_tab({1'b0, j});
		assign tb = pow2_tab({1'b0, j} + 5'd1);
		assign tdif = ta - tb;
		assign corr = CORR_W'(tdif) * CORR_W'(r) + CORR_W'(ROUND_HALF);
		assign g = ta - corr[FRAC_SHIFT +: E_W];

		always_ff @(posedge clk) begin
			if (en) begin
				e_s7.e[k] <= (n >= N_W'(EXP_CUTOFF)) ? '0 : (g >> n[4:0]);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/msac_divider.sv
// Pipelined restoring divider, one quotient bit per stage, one lane per class.
`default_nettype none
module msac_divider import msac_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic v_in,
	input wire logic [SUM_W-1:0] divisor,
	input wire logic [NUM_CLASSES-1:0][R_W-1:0] rem_in,
	input wire logic [NUM_CLASSES-1:0][Q_W-1:0] dq_in,
	output logic v_out,
	output logic [NUM_CLASSES-1:0][Q_W-1:0] quot
);

	logic v_s [DIV_STEPS];
	logic [SUM_W-1:0] div_s [DIV_STEPS];
	logic [NUM_CLASSES-1:0][R_W-1:0] rem_s [DIV_STEPS];
	logic [NUM_CLASSES-1:0][Q_W-1:0] dq_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic vp;
		logic [SUM_W-1:0] dp;
		logic [NUM_CLASSES-1:0][R_W-1:0] rp, rn;
		logic [NUM_CLASSES-1:0][Q_W-1:0] qp, qn;

		if (k == 0) begin : g_first
			assign vp = v_in;
			assign dp = divisor;
			assign rp = rem_in;
			assign qp = dq_in;
		end else begin : g_next
			assign vp = v_s[k-1];
			assign dp = div_s[k-1];
			assign rp = rem_s[k-1];
			assign qp = dq_s[k-1];
		end

		// The dividend bits shift out of the top of dq while quotient bits
		// shift in at the bottom.
		always_comb begin
			for (int l = 0; l < NUM_CLASSES; l++) begin
				if ({rp[l], qp[l][Q_W-1]} >= {1'b0, dp}) begin
					rn[l] = R_W'({rp[l], qp[l][Q_W-1]} - {1'b0, dp});
					qn[l] = {qp[l][Q_W-2:0], 1'b1};
				end else begin
					rn[l] = {rp[l][R_W-2:0], qp[l][Q_W-1]};
					qn[l] = {qp[l][Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= dp;
				rem_s[k] <= rn;
				dq_s[k] <= qn;
			end
		end
	end

	assign v_out = v_s[DIV_STEPS-1];
	assign quot = dq_s[DIV_STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/core/msac_back.sv
// Back pipeline: softmax normalization, saturation and the class decision.
`default_nettype none
module msac_back import msac_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire thr_cfg_t thr,
	input wire logic src_empty,
	input wire exp_item_t src_data,
	output logic src_pop,
	input wire logic dst_full,
	output logic dst_push,
	output out_item_t dst_data
);

	logic en;
	logic v_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [NUM_CLASSES-1:0][R_W-1:0] rem_s1;
	logic [NUM_CLASSES-1:0][Q_W-1:0] dq_s1;
	logic v_s2;
	logic [NUM_CLASSES-1:0][Q_W-1:0] quot_s2;
	logic v_s3;
	out_item_t res_s3;

	assign en = !v_s3 || !dst_full;
	assign src_pop = en && !src_empty;
	assign dst_push = v_s3 && !dst_full;
	assign dst_data = res_s3;

	// Stage 1: sum of exponents and the rounded dividend e * 65536 + S / 2.
	// The quotient never exceeds 65536, so the top dividend bits already form
	// a remainder below the divisor.
	logic [SUM_W-1:0] sum;
	logic [NUM_CLASSES-1:0][DIV_D_W-1:0] dvd;

	always_comb begin
		sum = '0;
		for (int l = 0; l < NUM_CLASSES; l++) begin
			sum = sum + SUM_W'(src_data.e[l]);
		end
		for (int l = 0; l < NUM_CLASSES; l++) begin
			dvd[l] = DIV_D_W'({src_data.e[l], 16'd0}) + DIV_D_W'(sum >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum;
			for (int l = 0; l < NUM_CLASSES; l++) begin
				rem_s1[l] <= R_W'(dvd[l][DIV_D_W-1:Q_W]);
				dq_s1[l] <= dvd[l][Q_W-1:0];
			end
		end
	end

	// Stage 2: the divide itself.
	msac_divider u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.v_in(v_s1),
		.divisor(sum_s1),
		.rem_in(rem_s1),
		.dq_in(dq_s1),
		.v_out(v_s2),
		.quot(quot_s2)
	);

	// Stage 3: saturate and decide.
	logic [NUM_CLASSES-1:0][PROB_W-1:0] prob;
	class_t cls;

	always_comb begin
		for (int l = 0; l < NUM_CLASSES; l++) begin
			prob[l] = quot_s2[l][Q_W-1] ? '1 : quot_s2[l][PROB_W-1:0];
		end
		if (prob[2] > thr.danger) begin
			cls = CLASS_DANGER;
		end else if (prob[1] > thr.warning) begin
			cls = CLASS_WARNING;
		end else begin
			cls = CLASS_NORMAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3.prob_normal <= prob[0];
			res_s3.prob_warning <= prob[1];
			res_s3.prob_danger <= prob[2];
			res_s3.class_code <= cls;
			res_s3.led_on <= (cls == CLASS_DANGER);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/mlp_sensor_anomaly_classifier_top.sv
// Throughput: one sample pair per cycle when the pipelines do not stall; the front
// and back pipelines are fully pipelined and the normalizing divider resolves one
// quotient bit per stage.
// A four-entry queue separates front from back, a two-entry queue holds results.
// Reset (arst_n low, asynchronous) empties all queues and pipelines and loads the
// thresholds with their defaults; no clearing pass is needed.
`default_nettype none
module mlp_sensor_anomaly_classifier_top import msac_pkg::*; #(
	parameter int HIDDEN_UNITS = MSAC_HIDDEN_UNITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire in_item_t sample,
	output logic full,
	output logic empty,
	input wire logic pop,
	output out_item_t result,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	thr_cfg_t thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.danger <= DANGER_THR_RESET;
			thr_q.warning <= WARNING_THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DANGER_THR: thr_q.danger <= cfg_data[THR_W-1:0];
				REG_WARNING_THR: thr_q.warning <= cfg_data[THR_W-1:0];
				default: thr_q <= thr_q;
			endcase
		end
	end

	logic mid_push, mid_full, mid_pop, mid_empty;
	exp_item_t mid_wdata, mid_rdata;
	logic out_push, out_full;
	out_item_t out_wdata;

	msac_front #(
		.HIDDEN_UNITS(HIDDEN_UNITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.sample(sample),
		.full(full),
		.q_push(mid_push),
		.q_data(mid_wdata),
		.q_full(mid_full)
	);

	msac_fifo #(
		.DATA_W($bits(exp_item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(mid_push),
		.wdata(mid_wdata),
		.full(mid_full),
		.pop(mid_pop),
		.rdata(mid_rdata),
		.empty(mid_empty)
	);

	msac_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.thr(thr_q),
		.src_empty(mid_empty),
		.src_data(mid_rdata),
		.src_pop(mid_pop),
		.dst_full(out_full),
		.dst_push(out_push),
		.dst_data(out_wdata)
	);

	msac_fifo #(
		.DATA_W($bits(out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(out_push),
		.wdata(out_wdata),
		.full(out_full),
		.pop(pop),
		.rdata(result),
		.empty(empty)
	);

endmodule
`default_nettype wire

FILE: rtl/core/msac_checker.sv
// Port-level checks on the classifier results, bound to the top level.
`default_nettype none
module msac_checker import msac_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pop,
	input wire logic empty,
	input wire out_item_t result
);

	logic [PROB_W+1:0] psum;

	assign psum = (PROB_W + 2)'(result.prob_normal) + (PROB_W + 2)'(result.prob_warning)
		+ (PROB_W + 2)'(result.prob_danger);

	// Rounding of three quotients and saturation keep the sum near one.
	a_prob_sum: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (psum >= 18'd65534) && (psum <= 18'd65538))
		else $error("probabilities do not sum to one");

	a_led: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.led_on == (result.class_code == CLASS_DANGER)))
		else $error("LED drive disagrees with class decision");

	a_danger_prob: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.class_code == CLASS_DANGER)) |-> (result.prob_danger != '0))
		else $error("danger decided with zero danger probability");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

endmodule

bind mlp_sensor_anomaly_classifier_top msac_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pop(pop),
	.empty(empty),
	.result(result)
);
`default_nettype wire
